/* hw/rtl/mbt_pkg.sv */
// Shared types and widths for the mirror bounce tracer.
// No dependencies; imported by every module of the block.
package mbt_pkg;

	localparam int COORD_W  = 24;
	localparam int DIR_W    = 16;
	localparam int DIVN_W   = 64;
	localparam int DIVD_W   = 42;
	localparam int SQ_IN_W  = 50;
	localparam int SQ_OUT_W = 25;

	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
	} mirror_t;

endpackage

/* hw/rtl/mbt_cell.sv */
// One mirror cell of the rotating mirror ring.
// Depends on mbt_pkg (mirror_t).
module mbt_cell import mbt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    we,
	input  mirror_t wr_mirror,
	input  logic    rot,
	input  mirror_t nb_mirror,
	input  logic    nb_valid,
	output mirror_t mirror,
	output logic    valid
);

	mirror_t mirror_q;
	logic    valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (we) begin
			valid_q <= 1'b1;
		end else if (rot) begin
			valid_q <= nb_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mirror_q <= wr_mirror;
		end else if (rot) begin
			mirror_q <= nb_mirror;
		end
	end

	assign mirror = mirror_q;
	assign valid  = valid_q;

endmodule

/* hw/rtl/mbt_div.sv */
// Unsigned restoring divider, two quotient bits per cycle.
// Depends on mbt_pkg (divider widths).
module mbt_div import mbt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVN_W-1:0] dividend,
	input  logic [DIVD_W-1:0] divisor,
	output logic              done,
	output logic [DIVN_W-1:0] quotient
);

	localparam int STEPS = DIVN_W / 2;
	localparam int CNT_W = $clog2(STEPS);

	logic [DIVN_W-1:0] quo_q;
	logic [DIVD_W-1:0] rem_q;
	logic [DIVD_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DIVN_W-1:0] quo_n;
	logic [DIVD_W-1:0] rem_n;
	logic [DIVD_W:0]   trial;

	always_comb begin
		quo_n = quo_q;
		rem_n = rem_q;
		trial = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_n, quo_n[DIVN_W-1]};
			quo_n = {quo_n[DIVN_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_n    = DIVD_W'(trial - {1'b0, dvs_q});
				quo_n[0] = 1'b1;
			end else begin
				rem_n = trial[DIVD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hw/rtl/mbt_sqrt.sv */
// Integer square root, one root bit per cycle (floor result).
// Depends on mbt_pkg (root widths).
module mbt_sqrt import mbt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SQ_IN_W-1:0]  radicand,
	output logic                done,
	output logic [SQ_OUT_W-1:0] root
);

	localparam int CNT_W = $clog2(SQ_OUT_W);
	localparam int REM_W = SQ_OUT_W + 2;

	logic [SQ_IN_W-1:0]  rad_q;
	logic [REM_W-1:0]    rem_q;
	logic [SQ_OUT_W-1:0] root_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                run_q;
	logic                done_q;
	logic [REM_W+1:0]    rem2;
	logic [REM_W+1:0]    trial;

	always_comb begin
		rem2  = {rem_q, rad_q[SQ_IN_W-1:SQ_IN_W-2]};
		trial = (REM_W + 2)'({root_q, 2'b01});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SQ_OUT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q <= {rad_q[SQ_IN_W-3:0], 2'b00};
			if (rem2 >= trial) begin
				rem_q  <= REM_W'(rem2 - trial);
				root_q <= {root_q[SQ_OUT_W-2:0], 1'b1};
			end else begin
				rem_q  <= REM_W'(rem2);
				root_q <= {root_q[SQ_OUT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* hw/rtl/ray_mirror_bounce_tracer.sv */
// Top level of the mirror bounce tracer: mirror cell ring, sequencer, shared
// multiplier. Depends on mbt_pkg, mbt_cell, mbt_div and mbt_sqrt.
//
// A mirror write (op 0) updates one slot. A trace (op 1) scans the mirror ring
// once per bounce: an empty or just-left slot is skipped, and a candidate mirror
// gets the hit test and, when it passes, a division in the shared divider. A hit
// adds the root unit, two normal divisions and multiplies.
// busy stays high for the whole trace. Each segment appears for one cycle with
// result_valid high and must be taken then: the receiver cannot stall the block.
module ray_mirror_bounce_tracer import mbt_pkg::*; #(
	parameter int MIRROR_SLOTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic [2:0]         mirror_slot,
	input  logic signed [23:0] end_a_x,
	input  logic signed [23:0] end_a_y,
	input  logic signed [23:0] end_b_x,
	input  logic signed [23:0] end_b_y,
	input  logic signed [23:0] origin_x,
	input  logic signed [23:0] origin_y,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	output logic               result_valid,
	output logic signed [23:0] seg_start_x,
	output logic signed [23:0] seg_start_y,
	output logic signed [23:0] seg_end_x,
	output logic signed [23:0] seg_end_y,
	output logic [5:0]         bounce_number,
	output logic               hit_mirror,
	output logic [2:0]         mirror_hit_slot,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [22:0]        cfg_data
);

	localparam int SLOT_W = (MIRROR_SLOTS > 1) ? $clog2(MIRROR_SLOTS) : 1;
	localparam int IDX_W  = $clog2(MIRROR_SLOTS + 1);
	localparam logic CFG_MAX_BOUNCES = 1'b0;
	localparam logic CFG_MAX_LENGTH  = 1'b1;
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TRACE = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE, ST_SCAN, ST_DEN1, ST_DEN2, ST_TN1, ST_TN2, ST_UN1, ST_UN2, ST_UNS,
		ST_TEST, ST_DIVU, ST_NEXT, ST_HX1, ST_HX2, ST_HY1, ST_HY2, ST_HEMIT,
		ST_NS1, ST_NS2, ST_NSQ, ST_NSQW, ST_NDXW, ST_NDYW, ST_RD1, ST_RD2, ST_RD3,
		ST_RR1, ST_RR2, ST_RR3, ST_FR1, ST_FR2, ST_FEMIT
	} state_t;

	function automatic logic signed [23:0] sat24(input logic signed [68:0] v);
		if (v > 69'sd8388607) begin
			sat24 = 24'sh7FFFFF;
		end else if (v < -69'sd8388608) begin
			sat24 = 24'sh800000;
		end else begin
			sat24 = v[23:0];
		end
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [68:0] v);
		if (v > 69'sd32767) begin
			sat16 = 16'sh7FFF;
		end else if (v < -69'sd32768) begin
			sat16 = 16'sh8000;
		end else begin
			sat16 = v[15:0];
		end
	endfunction

	state_t state_q;

	logic [5:0]  max_bounces_q;
	logic [22:0] max_length_q;

	mirror_t cell_m [MIRROR_SLOTS];
	logic    cell_v [MIRROR_SLOTS];
	mirror_t wr_mirror;
	logic    wr_en;
	logic    rot;

	logic [IDX_W-1:0]  idx_q;
	logic [SLOT_W-1:0] prev_q;
	logic              prev_v_q;
	logic [SLOT_W-1:0] best_q;
	logic              best_v_q;
	logic [63:0]       best_u_q;
	logic [5:0]        bounces_q;

	logic signed [23:0] ox_q, oy_q, px_q, py_q;
	logic signed [15:0] dx_q, dy_q, ndx_q, nx_q, ny_q;
	logic signed [24:0] ex_q, ey_q, wx_q, wy_q, bex_q, bey_q;
	logic signed [41:0] den_q, tn_q;
	logic signed [50:0] un_q;
	logic signed [35:0] dot2_q;
	logic [24:0]        len_q;

	logic signed [35:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [68:0] prod_q, acc_q;
	logic signed [68:0] acc_diff, acc_sum;

	logic signed [41:0] den_abs, tn_s;
	logic signed [50:0] un_s;
	logic               cand_pass;
	logic               skip;

	logic               div_start, div_done;
	logic [DIVN_W-1:0]  div_dividend, div_quot;
	logic [DIVD_W-1:0]  div_divisor;
	logic               sq_start, sq_done;
	logic [SQ_IN_W-1:0] sq_in;
	logic [SQ_OUT_W-1:0] sq_root;
	logic [24:0]        sq_len;
	logic [24:0]        bex_abs, bey_abs;

	logic signed [63:0] hit_p;
	logic signed [23:0] hit_coord;
	logic signed [23:0] free_x, free_y;
	logic signed [15:0] refl;
	logic [14:0]        norm_mag;
	logic               last_bounce;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign wr_en     = start && !busy && (op == OP_WRITE);
	assign wr_mirror = '{ax: end_a_x, ay: end_a_y, bx: end_b_x, by: end_b_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bounces_q <= 6'd20;
			max_length_q  <= 23'd751862;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAX_BOUNCES: max_bounces_q <= cfg_data[5:0];
				CFG_MAX_LENGTH:  max_length_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar k = 0; k < MIRROR_SLOTS; k++) begin : g_cell
		mbt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.we        (wr_en && ({4'b0, mirror_slot} == 7'(k))),
			.wr_mirror (wr_mirror),
			.rot       (rot),
			.nb_mirror (cell_m[(k + 1) % MIRROR_SLOTS]),
			.nb_valid  (cell_v[(k + 1) % MIRROR_SLOTS]),
			.mirror    (cell_m[k]),
			.valid     (cell_v[k])
		);
	end

	mbt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	mbt_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_in),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_comb begin
		acc_diff = acc_q - prod_q;
		acc_sum  = acc_q + prod_q;
		den_abs  = den_q[41] ? -den_q : den_q;
		tn_s     = den_q[41] ? -tn_q : tn_q;
		un_s     = den_q[41] ? -un_q : un_q;
		cand_pass = (den_q != 42'sd0) && (tn_s > 42'sd0) && (tn_s < den_abs)
			&& (un_s > 51'sd0);
		skip = !cell_v[0] || (prev_v_q && (idx_q[SLOT_W-1:0] == prev_q));
		sq_len  = (sq_root == '0) ? 25'd1 : sq_root;
		bex_abs = bex_q[24] ? 25'(-bex_q) : 25'(bex_q);
		bey_abs = bey_q[24] ? 25'(-bey_q) : 25'(bey_q);
		hit_p   = 64'(acc_q) + signed'({prod_q[31:0], 32'b0});
		hit_coord = sat24(69'((state_q == ST_HEMIT) ? oy_q : ox_q) + 69'(hit_p >>> 14));
		free_x  = sat24(69'(ox_q) + (acc_q >>> 14));
		free_y  = sat24(69'(oy_q) + (prod_q >>> 14));
		refl    = sat16(69'((state_q == ST_RR2) ? dx_q : dy_q)
			- ((prod_q + 69'sd134217728) >>> 28));
		norm_mag = (div_quot > 64'd16384) ? 15'd16384 : div_quot[14:0];
		last_bounce = (bounces_q + 6'd1) == max_bounces_q;
	end

	always_comb begin
		mul_a        = '0;
		mul_b        = '0;
		rot          = 1'b0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		sq_start     = 1'b0;
		sq_in        = '0;
		unique case (state_q)
			ST_SCAN: rot = (idx_q != IDX_W'(MIRROR_SLOTS)) && skip;
			ST_DEN1: begin mul_a = 36'(ex_q); mul_b = 33'(dy_q); end
			ST_DEN2: begin mul_a = 36'(ey_q); mul_b = 33'(dx_q); end
			ST_TN1:  begin mul_a = 36'(wx_q); mul_b = 33'(dy_q); end
			ST_TN2:  begin mul_a = 36'(wy_q); mul_b = 33'(dx_q); end
			ST_UN1:  begin mul_a = 36'(wx_q); mul_b = 33'(ey_q); end
			ST_UN2:  begin mul_a = 36'(wy_q); mul_b = 33'(ex_q); end
			ST_TEST: begin
				div_start    = cand_pass;
				div_dividend = {un_s[49:0], 14'b0};
				div_divisor  = den_abs[DIVD_W-1:0];
			end
			ST_NEXT: rot = 1'b1;
			ST_HX1: begin mul_a = 36'(dx_q); mul_b = signed'({1'b0, best_u_q[31:0]}); end
			ST_HX2: begin mul_a = 36'(dx_q); mul_b = signed'({2'b0, best_u_q[62:32]}); end
			ST_HY1: begin mul_a = 36'(dy_q); mul_b = signed'({1'b0, best_u_q[31:0]}); end
			ST_HY2: begin mul_a = 36'(dy_q); mul_b = signed'({2'b0, best_u_q[62:32]}); end
			ST_NS1: begin mul_a = 36'(bex_q); mul_b = 33'(bex_q); end
			ST_NS2: begin mul_a = 36'(bey_q); mul_b = 33'(bey_q); end
			ST_NSQ: begin
				sq_start = 1'b1;
				sq_in    = acc_sum[SQ_IN_W-1:0];
			end
			ST_NSQW: begin
				div_start    = sq_done;
				div_dividend = 64'({bey_abs, 14'b0});
				div_divisor  = DIVD_W'(sq_len);
			end
			ST_NDXW: begin
				div_start    = div_done;
				div_dividend = 64'({bex_abs, 14'b0});
				div_divisor  = DIVD_W'(len_q);
			end
			ST_RD1: begin mul_a = 36'(dx_q); mul_b = 33'(nx_q); end
			ST_RD2: begin mul_a = 36'(dy_q); mul_b = 33'(ny_q); end
			ST_RR1: begin mul_a = dot2_q; mul_b = 33'(nx_q); end
			ST_RR2: begin mul_a = dot2_q; mul_b = 33'(ny_q); end
			ST_FR1: begin mul_a = 36'(dx_q); mul_b = signed'({10'b0, max_length_q}); end
			ST_FR2: begin mul_a = 36'(dy_q); mul_b = signed'({10'b0, max_length_q}); end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			result_valid <= 1'b0;
			idx_q        <= '0;
			prev_v_q     <= 1'b0;
			best_v_q     <= 1'b0;
			bounces_q    <= '0;
		end else begin
			result_valid <= 1'b0;
			prod_q       <= mul_a * mul_b;
			unique case (state_q)
				ST_IDLE: begin
					if (start && op == OP_TRACE) begin
						ox_q      <= origin_x;
						oy_q      <= origin_y;
						dx_q      <= dir_x;
						dy_q      <= dir_y;
						bounces_q <= '0;
						prev_v_q  <= 1'b0;
						best_v_q  <= 1'b0;
						idx_q     <= '0;
						if (max_bounces_q != 6'd0) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (idx_q == IDX_W'(MIRROR_SLOTS)) begin
						state_q <= best_v_q ? ST_HX1 : ST_FR1;
					end else if (skip) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						ex_q    <= {cell_m[0].bx[23], cell_m[0].bx} - {cell_m[0].ax[23], cell_m[0].ax};
						ey_q    <= {cell_m[0].by[23], cell_m[0].by} - {cell_m[0].ay[23], cell_m[0].ay};
						wx_q    <= {ox_q[23], ox_q} - {cell_m[0].ax[23], cell_m[0].ax};
						wy_q    <= {oy_q[23], oy_q} - {cell_m[0].ay[23], cell_m[0].ay};
						state_q <= ST_DEN1;
					end
				end
				ST_DEN1: state_q <= ST_DEN2;
				ST_DEN2: begin acc_q <= prod_q; state_q <= ST_TN1; end
				ST_TN1:  begin den_q <= 42'(acc_diff); state_q <= ST_TN2; end
				ST_TN2:  begin acc_q <= prod_q; state_q <= ST_UN1; end
				ST_UN1:  begin tn_q <= 42'(acc_diff); state_q <= ST_UN2; end
				ST_UN2:  begin acc_q <= prod_q; state_q <= ST_UNS; end
				ST_UNS:  begin un_q <= 51'(acc_diff); state_q <= ST_TEST; end
				ST_TEST: state_q <= cand_pass ? ST_DIVU : ST_NEXT;
				ST_DIVU: begin
					if (div_done) begin
						if (!best_v_q || div_quot < best_u_q) begin
							best_v_q <= 1'b1;
							best_u_q <= div_quot;
							best_q   <= idx_q[SLOT_W-1:0];
							bex_q    <= ex_q;
							bey_q    <= ey_q;
						end
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= ST_SCAN;
				end
				ST_HX1: state_q <= ST_HX2;
				ST_HX2: begin acc_q <= prod_q; state_q <= ST_HY1; end
				ST_HY1: begin px_q <= hit_coord; state_q <= ST_HY2; end
				ST_HY2: begin acc_q <= prod_q; state_q <= ST_HEMIT; end
				ST_HEMIT: begin
					py_q            <= hit_coord;
					result_valid    <= 1'b1;
					seg_start_x     <= ox_q;
					seg_start_y     <= oy_q;
					seg_end_x       <= px_q;
					seg_end_y       <= hit_coord;
					bounce_number   <= bounces_q;
					hit_mirror      <= 1'b1;
					mirror_hit_slot <= 3'(best_q);
					last            <= last_bounce;
					state_q         <= ST_NS1;
				end
				ST_NS1: state_q <= ST_NS2;
				ST_NS2: begin acc_q <= prod_q; state_q <= ST_NSQ; end
				ST_NSQ: state_q <= ST_NSQW;
				ST_NSQW: begin
					if (sq_done) begin
						len_q   <= sq_len;
						state_q <= ST_NDXW;
					end
				end
				ST_NDXW: begin
					if (div_done) begin
						nx_q    <= (bey_q > 25'sd0) ? -signed'({1'b0, norm_mag})
							: signed'({1'b0, norm_mag});
						state_q <= ST_NDYW;
					end
				end
				ST_NDYW: begin
					if (div_done) begin
						ny_q    <= bex_q[24] ? -signed'({1'b0, norm_mag})
							: signed'({1'b0, norm_mag});
						state_q <= ST_RD1;
					end
				end
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: begin acc_q <= prod_q; state_q <= ST_RD3; end
				ST_RD3: begin dot2_q <= 36'(acc_sum) <<< 1; state_q <= ST_RR1; end
				ST_RR1: state_q <= ST_RR2;
				ST_RR2: begin ndx_q <= refl; state_q <= ST_RR3; end
				ST_RR3: begin
					dx_q      <= ndx_q;
					dy_q      <= refl;
					ox_q      <= px_q;
					oy_q      <= py_q;
					prev_q    <= best_q;
					prev_v_q  <= 1'b1;
					best_v_q  <= 1'b0;
					idx_q     <= '0;
					bounces_q <= bounces_q + 6'd1;
					state_q   <= last_bounce ? ST_IDLE : ST_SCAN;
				end
				ST_FR1: state_q <= ST_FR2;
				ST_FR2: begin acc_q <= prod_q; state_q <= ST_FEMIT; end
				ST_FEMIT: begin
					result_valid    <= 1'b1;
					seg_start_x     <= ox_q;
					seg_start_y     <= oy_q;
					seg_end_x       <= free_x;
					seg_end_y       <= free_y;
					bounce_number   <= bounces_q;
					hit_mirror      <= 1'b0;
					mirror_hit_slot <= 3'd0;
					last            <= 1'b1;
					state_q         <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid)
		else $error("beat follows final segment");

	a_free_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !hit_mirror |-> last && mirror_hit_slot == 3'd0)
		else $error("free segment not final");

	a_bounce_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> bounce_number < max_bounces_q)
		else $error("bounce count beyond limit");

	a_idle_after_free: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !hit_mirror |-> !busy)
		else $error("still busy after free segment");

endmodule

/* verif/tb_ray_mirror_bounce_tracer.sv */
// Self-checking testbench for ray_mirror_bounce_tracer: mirror table writes,
// ray traces in mirror boxes, register sweeps, checked against a built-in predictor.
// Depends on mbt_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_ray_mirror_bounce_tracer;
	import mbt_pkg::*;

	typedef enum logic {OP_WRITE = 1'b0, OP_TRACE = 1'b1} op_e;
	localparam logic REG_MAX_BOUNCES = 1'b0;
	localparam logic REG_MAX_LENGTH  = 1'b1;
	localparam int   STALL_LIMIT     = 20000;
	localparam int   UNIT            = 4096;

	typedef struct packed {
		logic [23:0] sx;
		logic [23:0] sy;
		logic [23:0] ex;
		logic [23:0] ey;
		logic [5:0]  bounce;
		logic        hit;
		logic [2:0]  slot;
		logic        is_last;
	} segment_t;

	logic clk, arst_n, start, busy, op;
	logic [2:0] mirror_slot;
	logic signed [23:0] end_a_x, end_a_y, end_b_x, end_b_y, origin_x, origin_y;
	logic signed [15:0] dir_x, dir_y;
	logic result_valid;
	logic signed [23:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
	logic [5:0] bounce_number;
	logic hit_mirror, last;
	logic [2:0] mirror_hit_slot;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [22:0] cfg_data;

	ray_mirror_bounce_tracer dut (.*);

	// predictor state
	longint mir_ax[8], mir_ay[8], mir_bx[8], mir_by[8];
	bit     mir_valid[8];
	int     bounce_limit = 20;
	longint free_length = 751862;

	segment_t segments_due[$];
	int errors = 0;
	int stall_cycles = 0;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic longint sat24(longint v);
		return v < -8388608 ? -8388608 : (v > 8388607 ? 8388607 : v);
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic void trace_ray(longint ox, longint oy, longint dx, longint dy);
		segment_t path[$];
		segment_t s;
		int hits, prev, best;
		longint best_u, ex, ey, wx, wy, den, tn, un, u, px, py, nx, ny, dot, len;
		longint unsigned q, r;
		hits = 0;
		prev = -1;
		while (hits < bounce_limit) begin
			best = -1;
			best_u = 0;
			for (int i = 0; i < 8; i++) begin
				if (!mir_valid[i] || i == prev) continue;
				ex = mir_bx[i] - mir_ax[i];
				ey = mir_by[i] - mir_ay[i];
				wx = ox - mir_ax[i];
				wy = oy - mir_ay[i];
				den = ex * dy - ey * dx;
				tn = wx * dy - wy * dx;
				un = wx * ey - wy * ex;
				if (den == 0) continue;
				if (den < 0) begin
					den = -den; tn = -tn; un = -un;
				end
				if (!(tn > 0 && tn < den && un > 0)) continue;
				q = longint'(un) / longint'(den);
				r = longint'(un) % longint'(den);
				u = longint'((q << 14) + (r << 14) / longint'(den));
				if (best < 0 || u < best_u) begin
					best = i;
					best_u = u;
				end
			end
			if (best < 0) break;
			px = sat24(ox + ((dx * best_u) >>> 14));
			py = sat24(oy + ((dy * best_u) >>> 14));
			s = '{ox[23:0], oy[23:0], px[23:0], py[23:0], hits[5:0], 1'b1, best[2:0], 1'b0};
			path = {path, s};
			ex = mir_bx[best] - mir_ax[best];
			ey = mir_by[best] - mir_ay[best];
			len = int_sqrt(ex * ex + ey * ey);
			if (len == 0) len = 1;
			nx = clip((-ey * 16384) / len, -16384, 16384);
			ny = clip((ex * 16384) / len, -16384, 16384);
			dot = dx * nx + dy * ny;
			dx = clip(dx - ((2 * dot * nx + (64'sd1 << 27)) >>> 28), -32768, 32767);
			dy = clip(dy - ((2 * dot * ny + (64'sd1 << 27)) >>> 28), -32768, 32767);
			ox = px;
			oy = py;
			prev = best;
			hits++;
		end
		if (hits < bounce_limit) begin
			px = sat24(ox + ((dx * free_length) >>> 14));
			py = sat24(oy + ((dy * free_length) >>> 14));
			s = '{ox[23:0], oy[23:0], px[23:0], py[23:0], hits[5:0], 1'b0, 3'd0, 1'b0};
			path = {path, s};
		end
		if (path.size() > 0) path[path.size()-1].is_last = 1'b1;
		foreach (path[k]) segments_due = {segments_due, path[k]};
	endfunction

	// result check
	always @(posedge clk) begin
		if (result_valid) begin
			segment_t got, want;
			got = '{seg_start_x, seg_start_y, seg_end_x, seg_end_y, bounce_number,
				hit_mirror, mirror_hit_slot, last};
			if (segments_due.size() == 0) begin
				$display("%t unexpected segment %p", $realtime, got);
				errors++;
			end else begin
				want = segments_due.pop_front();
				if (got !== want) begin
					$display("%t segment mismatch: expected %p actual %p",
						$realtime, want, got);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (result_valid || (start && !busy) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic random_pause();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return;
		if (p < 90) pause($urandom_range(1, 3));
		else pause($urandom_range(10, 60));
	endtask

	task automatic send_beat(op_e o, logic [2:0] sl, logic [23:0] ax, ay, bx, by,
			logic [23:0] ox, oy, logic [15:0] dx, dy);
		op <= o; mirror_slot <= sl;
		end_a_x <= ax; end_a_y <= ay; end_b_x <= bx; end_b_y <= by;
		origin_x <= ox; origin_y <= oy; dir_x <= dx; dir_y <= dy;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (o == OP_WRITE) begin
			mir_ax[sl] = $signed(ax); mir_ay[sl] = $signed(ay);
			mir_bx[sl] = $signed(bx); mir_by[sl] = $signed(by);
			mir_valid[sl] = 1'b1;
		end else begin
			trace_ray($signed(ox), $signed(oy), $signed(dx), $signed(dy));
		end
		random_pause();
	endtask

	task automatic put_mirror(int sl, int ax, int ay, int bx, int by);
		send_beat(OP_WRITE, 3'(sl), 24'(ax), 24'(ay), 24'(bx), 24'(by),
			24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic shoot(int ox, int oy, int dx, int dy);
		send_beat(OP_TRACE, 3'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
			24'($urandom), 24'(ox), 24'(oy), 16'(dx), 16'(dy));
	endtask

	task automatic drain();
		pause(1);
		while (segments_due.size() != 0 || busy) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int value);
		drain();
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= 23'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_MAX_BOUNCES) bounce_limit = value & 63;
		else free_length = value & 23'h7fffff;
	endtask

	task automatic shoot_unit(int ox, int oy);
		real a;
		a = $urandom_range(0, 62831) / 10000.0;
		shoot(ox, oy, $rtoi(16384.0 * $cos(a)), $rtoi(16384.0 * $sin(a)));
	endtask

	// closed box of four walls, corners overlapped; random interior mirrors
	task automatic build_box(int half, int inner);
		int m, w[4][4];
		int order[$];
		m = half / 8 + 4;
		w[0] = '{-half - m, -half, half + m, -half};
		w[1] = '{half, -half - m, half, half + m};
		w[2] = '{half + m, half, -half - m, half};
		w[3] = '{-half, half + m, -half, -half - m};
		order = '{0, 1, 2, 3};
		order.shuffle();
		for (int i = 0; i < 4; i++)
			if ($urandom_range(0, 1))
				put_mirror(i, w[order[i]][0], w[order[i]][1], w[order[i]][2], w[order[i]][3]);
			else
				put_mirror(i, w[order[i]][2], w[order[i]][3], w[order[i]][0], w[order[i]][1]);
		for (int i = 4; i < 4 + inner; i++)
			put_mirror(i, $urandom_range(0, 2 * half) - half, $urandom_range(0, 2 * half) - half,
				$urandom_range(0, 2 * half) - half, $urandom_range(0, 2 * half) - half);
	endtask

	task automatic test_empty_table();
		shoot(0, 0, 16384, 0);
		shoot(-8388608, 8388607, -16384, 16384);
		shoot(8388607, -8388608, 16384, -16384);
		shoot(12345, -6789, 0, 0);
	endtask

	task automatic test_directed();
		write_reg(REG_MAX_LENGTH, 8388607);
		shoot(8388607, 8388607, 16384, 16384);
		shoot(-8388608, -8388608, -16384, -16384);
		build_box(50 * UNIT, 0);
		shoot(0, 0, 16384, 0);
		shoot(10 * UNIT, -3 * UNIT, 11585, 11585);
		shoot(0, 0, 0, 0);
		put_mirror(4, -8388608, -8388608, 8388607, 8388607);
		put_mirror(5, 8388607, -8388608, -8388608, 8388607);
		put_mirror(6, 5 * UNIT, -10 * UNIT, 5 * UNIT, 10 * UNIT);
		shoot(0, 0, 0, 16384);
		shoot(0, 5 * UNIT, 16384, 0);
		put_mirror(7, 0, 0, 0, 0);
		shoot(-UNIT, UNIT, 16384, -16384);
		write_reg(REG_MAX_BOUNCES, 0);
		shoot(0, 0, 16384, 0);
		write_reg(REG_MAX_BOUNCES, 1);
		write_reg(REG_MAX_LENGTH, 0);
		shoot(UNIT, UNIT, -16384, 0);
	endtask

	task automatic test_register_sweep();
		int limits[5] = '{63, 2, 0, 3, 1};
		build_box(20 * UNIT, 2);
		foreach (limits[i]) begin
			write_reg(REG_MAX_BOUNCES, limits[i]);
			write_reg(REG_MAX_LENGTH, $urandom_range(0, 8388607));
			repeat (3) shoot_unit($urandom_range(0, 30 * UNIT) - 15 * UNIT,
				$urandom_range(0, 30 * UNIT) - 15 * UNIT);
		end
	endtask

	task automatic test_random();
		int half, lim, n;
		for (int phase = 0; phase < 9; phase++) begin
			lim = $urandom_range(1, 10);
			write_reg(REG_MAX_BOUNCES, lim);
			write_reg(REG_MAX_LENGTH, $urandom_range(0, 3) == 0 ? 8388607
				: $urandom_range(0, 1000000));
			half = $urandom_range(1, 1500) * 1024;
			build_box(half, $urandom_range(0, 4));
			n = 0;
			while (n < 28) begin
				case ($urandom_range(0, 9))
					0: shoot($urandom, $urandom, $urandom, $urandom);
					1: put_mirror($urandom_range(4, 7), $urandom, $urandom, $urandom, $urandom);
					default: shoot_unit($urandom_range(0, 2 * half - 2) - half + 1,
						$urandom_range(0, 2 * half - 2) - half + 1);
				endcase
				n++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0; op = OP_WRITE; mirror_slot = '0;
		end_a_x = '0; end_a_y = '0; end_b_x = '0; end_b_y = '0;
		origin_x = '0; origin_y = '0; dir_x = '0; dir_y = '0;
		cfg_valid = 1'b0; cfg_index = REG_MAX_BOUNCES; cfg_data = '0;
		foreach (mir_valid[i]) mir_valid[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_directed();
		test_register_sweep();
		test_random();
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && segments_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* ray_mirror_bounce_tracer.f */
hw/rtl/mbt_pkg.sv
hw/rtl/mbt_cell.sv
hw/rtl/mbt_div.sv
hw/rtl/mbt_sqrt.sv
hw/rtl/ray_mirror_bounce_tracer.sv
verif/tb_ray_mirror_bounce_tracer.sv
